// ===== hdl/wts_pkg.sv =====
// Package for the sixteen-channel wavetable synthesizer.
// Types, constants and lookup functions shared by the controller, datapath and top; no dependencies.
package wts_pkg;

  localparam int RAM_BYTES = 2048;
  localparam int RAM_AW = 11;
  localparam int CH_COUNT = 16;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  localparam logic [0:0] CFG_ENABLED = 1'd0;
  localparam logic [0:0] CFG_VOLUME = 1'd1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // register rows, relative to the set base
  localparam logic [2:0] ROW_FLO = 3'd0;
  localparam logic [2:0] ROW_FMID = 3'd1;
  localparam logic [2:0] ROW_FHI = 3'd2;
  localparam logic [2:0] ROW_WAVE = 3'd5;
  localparam logic [2:0] ROW_AMP = 3'd6;
  localparam logic [2:0] ROW_CTRL = 3'd7;

  // ceil(2^31 / 100): x / 100 is (x * DIV100_M) >> 31 for x below 2^25
  localparam logic [24:0] DIV100_M = 25'd21474837;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CLEAR, ST_BUS, ST_BUS_WAIT, ST_RD_OUT,
    ST_STEP, ST_R_FLO, ST_R_FMID, ST_R_FHI, ST_R_WAVE, ST_R_AMP, ST_R_CTRL,
    ST_FETCH, ST_SCALE, ST_D2A, ST_PAN, ST_ACC, ST_VOL, ST_VOL2, ST_FRAME
  } state_t;

  typedef struct packed {
    logic       clr_wr;      // write zero at clear address
    logic       clr_inc;
    logic       bus_rd;      // issue RAM read at bus offset
    logic       bus_wr;
    logic       cap_rd;      // capture read data into output reg
    logic       reg_rd;      // issue RAM read of a register row
    logic [2:0] row;
    logic       lat_flo;
    logic       lat_fmid;
    logic       lat_fhi;
    logic       lat_wave;
    logic       lat_amp;
    logic       lat_ctrl;
    logic       smp_rd;      // update phase, issue sample fetch
    logic       do_scale;
    logic       do_d2a;
    logic       do_pan;
    logic       do_acc;
    logic       do_vol;
    logic       do_vol2;
    logic       frame_end;   // clear sums, reset alt set
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic wrap;        // channel index wrapped to zero by this step
  } dp_sts_t;

  function automatic logic [12:0] base_x4(input logic [2:0] c);
    case (c)
      3'd0: base_x4 = 13'd0;
      3'd1: base_x4 = 13'd33;
      3'd2: base_x4 = 13'd99;
      3'd3: base_x4 = 13'd231;
      3'd4: base_x4 = 13'd495;
      3'd5: base_x4 = 13'd1023;
      3'd6: base_x4 = 13'd2079;
      default: base_x4 = 13'd4191;
    endcase
  endfunction

  function automatic logic [6:0] pan_l(input logic [3:0] p);
    case (p)
      4'd8, 4'd9, 4'd10: pan_l = 7'd0;
      4'd11: pan_l = 7'd17;
      4'd12: pan_l = 7'd33;
      4'd13: pan_l = 7'd50;
      4'd14: pan_l = 7'd67;
      4'd15: pan_l = 7'd83;
      default: pan_l = 7'd100;
    endcase
  endfunction

  function automatic logic [6:0] pan_r(input logic [3:0] p);
    pan_r = 7'd100 - pan_l(p);
  endfunction

  // pan weight times DIV100_M: one multiply gives sample * pan / 100
  function automatic logic [31:0] pan_lk(input logic [3:0] p);
    case (p)
      4'd8, 4'd9, 4'd10: pan_lk = 32'd0;
      4'd11: pan_lk = 32'd365072229;
      4'd12: pan_lk = 32'd708669621;
      4'd13: pan_lk = 32'd1073741850;
      4'd14: pan_lk = 32'd1438814079;
      4'd15: pan_lk = 32'd1782411471;
      default: pan_lk = 32'd2147483700;
    endcase
  endfunction

  function automatic logic [31:0] pan_rk(input logic [3:0] p);
    case (p)
      4'd8, 4'd9, 4'd10: pan_rk = 32'd2147483700;
      4'd11: pan_rk = 32'd1782411471;
      4'd12: pan_rk = 32'd1438814079;
      4'd13: pan_rk = 32'd1073741850;
      4'd14: pan_rk = 32'd708669621;
      4'd15: pan_rk = 32'd365072229;
      default: pan_rk = 32'd0;
    endcase
  endfunction

endpackage

// ===== hdl/wts_if.sv =====
// Valid/ready channel interfaces for the synthesizer.
// Depends on nothing.
interface wts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] page;
  logic [7:0] address;
  logic [7:0] write_data;
  logic [5:0] cycles;
  modport source (output valid, op, page, address, write_data, cycles, input ready);
  modport sink (input valid, op, page, address, write_data, cycles, output ready);
endinterface

interface wts_out_if;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [7:0]        read_data;
  logic signed [15:0] left;
  logic signed [15:0] right;
  logic              last;
  modport source (output valid, kind, read_data, left, right, last, input ready);
  modport sink (input valid, kind, read_data, left, right, last, output ready);
endinterface

// ===== hdl/wts_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
module wts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== hdl/wts_datapath.sv =====
// Synthesizer datapath: wave RAM, phases, channel math, sums and frame output.
// Depends on wts_pkg and wts_ram.
module wts_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  wts_pkg::dp_cmd_t     cmd,
  output wts_pkg::dp_sts_t     sts,
  input  logic [7:0]           bus_page,
  input  logic [7:0]           bus_addr,
  input  logic [7:0]           bus_wdata,
  input  logic                 bus_mapped,
  input  logic [6:0]           volume,
  output logic [7:0]           rd_data,
  output logic signed [15:0]   left,
  output logic signed [15:0]   right
);
  localparam int AW = wts_pkg::RAM_AW;

  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [3:0]    ch_r;
  logic          alt_r;
  logic [23:0]   phase_r [wts_pkg::CH_COUNT];
  logic [7:0]    flo_r, fmid_r, fhi_r, wave_r, amp_r, ctrl_r;
  logic [7:0]    rd_data_r;
  logic          sign_r;
  logic [14:0]   prod_r;
  logic [6:0]    mag_r;
  logic [12:0]   dmag_r;
  logic signed [13:0] pl_r, pr_r;
  logic signed [17:0] lsum_r, rsum_r;
  logic [24:0]   vlm_r, vrm_r;
  logic          vls_r, vrs_r;
  logic signed [15:0] left_r, right_r;

  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [23:0]   phase_new;
  logic [AW-1:0] bus_off;
  logic [7:0]    amp_cap;
  logic          sign_now;
  logic [12:0]   d2a_val;
  logic [44:0]   pan_pl, pan_pr;
  logic [17:0]   lmag, rmag;
  logic [49:0]   vol_ql, vol_qr;

  // saturate a sign and magnitude pair to 16 bits
  function automatic logic signed [15:0] sat_mag(input logic neg, input logic [17:0] m);
    if (neg) begin
      if (m >= 18'd32768) sat_mag = -16'sd32768;
      else sat_mag = -$signed({1'b0, m[14:0]});
    end else begin
      if (m >= 18'd32767) sat_mag = 16'sd32767;
      else sat_mag = $signed({1'b0, m[14:0]});
    end
  endfunction

  wts_ram #(.WIDTH(8), .DEPTH(wts_pkg::RAM_BYTES)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  assign bus_off = {bus_page[3:1], bus_addr};
  assign phase_new = phase_r[ch_r] + {fhi_r, fmid_r, flo_r[7:1], 1'b0};
  assign sts.clr_done = &clr_addr_r;
  assign sts.wrap = (ch_r == 4'd0);
  assign clr_addr_nxt = clr_addr_r + 1'b1;
  assign amp_cap = (amp_r > 8'h80) ? 8'h80 : amp_r;
  assign sign_now = ram_rdata[7] ^ ctrl_r[4];

  // log D/A law: chord base plus step shifted by chord + 1
  assign d2a_val = wts_pkg::base_x4(mag_r[6:4])
                 + (13'(mag_r[3:0]) << ({1'b0, mag_r[6:4]} + 4'd1));

  // pan weight and divide by 100 folded into one constant multiply
  assign pan_pl = dmag_r * wts_pkg::pan_lk(ctrl_r[3:0]);
  assign pan_pr = dmag_r * wts_pkg::pan_rk(ctrl_r[3:0]);

  // sum magnitudes, and volume product divided by 100
  assign lmag = lsum_r[17] ? -lsum_r : lsum_r;
  assign rmag = rsum_r[17] ? -rsum_r : rsum_r;
  assign vol_ql = vlm_r * wts_pkg::DIV100_M;
  assign vol_qr = vrm_r * wts_pkg::DIV100_M;

  // RAM port selection
  always_comb begin
    ram_we = 1'b0;
    ram_wdata = bus_wdata;
    ram_addr = bus_off;
    if (cmd.clr_wr) begin
      ram_we = 1'b1;
      ram_wdata = 8'd0;
      ram_addr = clr_addr_r;
    end else if (cmd.bus_wr) begin
      ram_we = bus_mapped;
    end else if (cmd.reg_rd) begin
      ram_addr = {3'b111, alt_r, cmd.row, ch_r};
    end else if (cmd.smp_rd) begin
      ram_addr = {wave_r[7:4], phase_new[23:17]};
    end
  end

  // control-ish state: clear pointer, channel, alternate set, phases and sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      ch_r <= '0;
      alt_r <= 1'b0;
      lsum_r <= '0;
      rsum_r <= '0;
      for (int i = 0; i < wts_pkg::CH_COUNT; i++) phase_r[i] <= '0;
    end else begin
      if (cmd.clr_inc) clr_addr_r <= clr_addr_nxt;
      if (cmd.smp_rd) phase_r[ch_r] <= phase_new;
      if (cmd.do_scale) begin
        alt_r <= ctrl_r[5] & sign_now;
        ch_r <= ch_r + 1'b1;
      end
      if (cmd.do_acc && !flo_r[0]) begin
        lsum_r <= lsum_r + 18'(pl_r);
        rsum_r <= rsum_r + 18'(pr_r);
      end
      if (cmd.frame_end) begin
        alt_r <= 1'b0;
        lsum_r <= '0;
        rsum_r <= '0;
      end
    end
  end

  // channel pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.cap_rd) rd_data_r <= bus_mapped ? ram_rdata : 8'hFF;
    if (cmd.lat_flo) flo_r <= ram_rdata;
    if (cmd.lat_fmid) fmid_r <= ram_rdata;
    if (cmd.lat_fhi) fhi_r <= ram_rdata;
    if (cmd.lat_wave) wave_r <= ram_rdata;
    if (cmd.lat_amp) amp_r <= ram_rdata;
    if (cmd.lat_ctrl) ctrl_r <= ram_rdata;
    // sample arrives the cycle after smp_rd: product and sign
    if (cmd.do_scale) begin
      sign_r <= sign_now;
      prod_r <= 15'(ram_rdata[6:0] * amp_cap);
    end
    if (cmd.do_d2a) mag_r <= prod_r[13:7];
    if (cmd.do_pan) dmag_r <= d2a_val;
    if (cmd.do_vol) begin
      vlm_r <= lmag * volume;
      vrm_r <= rmag * volume;
      vls_r <= lsum_r[17];
      vrs_r <= rsum_r[17];
    end
    if (cmd.do_vol2) begin
      left_r <= sat_mag(vls_r, vol_ql[48:31]);
      right_r <= sat_mag(vrs_r, vol_qr[48:31]);
    end
  end

  // panned samples, registered one stage before the sum; truncated toward zero
  always_ff @(posedge clk) begin
    pl_r <= sign_r ? -$signed({1'b0, pan_pl[43:31]}) : $signed({1'b0, pan_pl[43:31]});
    pr_r <= sign_r ? -$signed({1'b0, pan_pr[43:31]}) : $signed({1'b0, pan_pr[43:31]});
  end

  assign rd_data = rd_data_r;
  assign left = left_r;
  assign right = right_r;
endmodule

// ===== hdl/wts_ctrl.sv =====
// Synthesizer controller: sequences bus requests, RAM clear and channel steps.
// Depends on wts_pkg.
module wts_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [5:0]        in_cycles,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_kind,
  output logic              out_last,
  output wts_pkg::dp_cmd_t  cmd,
  input  wts_pkg::dp_sts_t  sts
);
  wts_pkg::state_t state_r, state_nxt;
  logic [1:0] op_r, op_nxt;
  logic [2:0] rem_r, rem_nxt;
  logic [4:0] steps_r, steps_nxt;
  logic [1:0] frames_r, frames_nxt;
  logic       ov_r, ov_nxt, kind_r, kind_nxt, last_r, last_nxt;
  logic [8:0] count;

  assign count = 9'(rem_r) + 9'(in_cycles) * 9'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wts_pkg::ST_CLEAR;
      op_r <= '0;
      rem_r <= '0;
      steps_r <= '0;
      frames_r <= '0;
      ov_r <= 1'b0;
      kind_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
      rem_r <= rem_nxt;
      steps_r <= steps_nxt;
      frames_r <= frames_nxt;
      ov_r <= ov_nxt;
      kind_r <= kind_nxt;
      last_r <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    rem_nxt = rem_r;
    steps_nxt = steps_r;
    frames_nxt = frames_r;
    ov_nxt = ov_r;
    kind_nxt = kind_r;
    last_nxt = last_r;
    cmd = '0;
    in_ready = 1'b0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      wts_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        cmd.clr_inc = 1'b1;
        if (sts.clr_done) state_nxt = wts_pkg::ST_IDLE;
      end
      wts_pkg::ST_IDLE: begin
        in_ready = !ov_r;
        if (in_valid && !ov_r) begin
          op_nxt = in_op;
          unique case (in_op)
            wts_pkg::OP_WRITE: state_nxt = wts_pkg::ST_BUS;
            wts_pkg::OP_READ: state_nxt = wts_pkg::ST_BUS;
            wts_pkg::OP_ADVANCE: begin
              rem_nxt = count[2:0];
              steps_nxt = count[7:3];
              frames_nxt = '0;
              state_nxt = wts_pkg::ST_STEP;
            end
            default: state_nxt = wts_pkg::ST_IDLE;
          endcase
        end
      end
      wts_pkg::ST_BUS: begin
        if (op_r == wts_pkg::OP_WRITE) begin
          cmd.bus_wr = 1'b1;
          state_nxt = wts_pkg::ST_IDLE;
        end else begin
          cmd.bus_rd = 1'b1;
          state_nxt = wts_pkg::ST_BUS_WAIT;
        end
      end
      wts_pkg::ST_BUS_WAIT: begin
        cmd.cap_rd = 1'b1;
        state_nxt = wts_pkg::ST_RD_OUT;
      end
      wts_pkg::ST_RD_OUT: begin
        ov_nxt = 1'b1;
        kind_nxt = wts_pkg::KIND_READ;
        last_nxt = 1'b1;
        state_nxt = wts_pkg::ST_IDLE;
      end
      wts_pkg::ST_STEP: begin
        if (ov_r) begin
          state_nxt = wts_pkg::ST_STEP;
        end else if (steps_r == '0) begin
          state_nxt = wts_pkg::ST_IDLE;
        end else begin
          cmd.reg_rd = 1'b1;
          cmd.row = wts_pkg::ROW_FLO;
          state_nxt = wts_pkg::ST_R_FLO;
        end
      end
      wts_pkg::ST_R_FLO: begin
        cmd.lat_flo = 1'b1; cmd.reg_rd = 1'b1; cmd.row = wts_pkg::ROW_FMID;
        state_nxt = wts_pkg::ST_R_FMID;
      end
      wts_pkg::ST_R_FMID: begin
        cmd.lat_fmid = 1'b1; cmd.reg_rd = 1'b1; cmd.row = wts_pkg::ROW_FHI;
        state_nxt = wts_pkg::ST_R_FHI;
      end
      wts_pkg::ST_R_FHI: begin
        cmd.lat_fhi = 1'b1; cmd.reg_rd = 1'b1; cmd.row = wts_pkg::ROW_WAVE;
        state_nxt = wts_pkg::ST_R_WAVE;
      end
      wts_pkg::ST_R_WAVE: begin
        cmd.lat_wave = 1'b1; cmd.reg_rd = 1'b1; cmd.row = wts_pkg::ROW_AMP;
        state_nxt = wts_pkg::ST_R_AMP;
      end
      wts_pkg::ST_R_AMP: begin
        cmd.lat_amp = 1'b1; cmd.reg_rd = 1'b1; cmd.row = wts_pkg::ROW_CTRL;
        state_nxt = wts_pkg::ST_R_CTRL;
      end
      wts_pkg::ST_R_CTRL: begin
        cmd.lat_ctrl = 1'b1;
        state_nxt = wts_pkg::ST_FETCH;
      end
      wts_pkg::ST_FETCH: begin
        cmd.smp_rd = 1'b1;
        state_nxt = wts_pkg::ST_SCALE;
      end
      wts_pkg::ST_SCALE: begin
        cmd.do_scale = 1'b1;
        state_nxt = wts_pkg::ST_D2A;
      end
      wts_pkg::ST_D2A: begin
        cmd.do_d2a = 1'b1;
        state_nxt = wts_pkg::ST_PAN;
      end
      wts_pkg::ST_PAN: begin
        cmd.do_pan = 1'b1;
        state_nxt = wts_pkg::ST_ACC;
      end
      wts_pkg::ST_ACC: begin
        // panned samples pl_r and pr_r register here, ahead of the sum
        state_nxt = wts_pkg::ST_VOL;
      end
      wts_pkg::ST_VOL: begin
        cmd.do_acc = 1'b1;
        steps_nxt = steps_r - 1'b1;
        if (sts.wrap) state_nxt = wts_pkg::ST_VOL2;
        else state_nxt = wts_pkg::ST_STEP;
      end
      wts_pkg::ST_VOL2: begin
        cmd.do_vol = 1'b1;
        state_nxt = wts_pkg::ST_FRAME;
      end
      wts_pkg::ST_FRAME: begin
        cmd.do_vol2 = 1'b1;
        cmd.frame_end = 1'b1;
        if (frames_r != 2'd2) begin
          ov_nxt = 1'b1;
          kind_nxt = wts_pkg::KIND_FRAME;
          // last when no later step can complete another frame, or on the second frame
          last_nxt = (steps_r < 5'd16) || (frames_r == 2'd1);
          frames_nxt = frames_r + 1'b1;
        end
        state_nxt = wts_pkg::ST_STEP;
      end
      default: state_nxt = wts_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_kind = kind_r;
  assign out_last = last_r;
endmodule

// ===== hdl/wavetable_synth_16ch_core.sv =====
// Top level of the sixteen-channel wavetable synthesizer.
// Depends on wts_pkg, wts_if, wts_ctrl, wts_datapath, wts_ram.
//
//  channel | direction | carries
//  in      | sink      | op, page, address, write_data, cycles
//  out     | source    | kind, read_data, left, right, last
//  cfg     | write     | enabled, volume
//
// A bus write runs IDLE, BUS; a bus read runs IDLE, BUS, BUS_WAIT, RD_OUT
// and then waits at the output. A channel step runs STEP, six register
// reads and one sample fetch on the single RAM port, then SCALE, D2A, PAN,
// ACC, VOL; each frame adds VOL2, FRAME. Reset clears all 2048 RAM bytes.
// A frame waiting at the output holds the step sequencer.
module wavetable_synth_16ch_core (
  input  logic      clk,
  input  logic      rst_n,
  wts_in_if.sink    in_ch,
  wts_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [6:0] cfg_data
);
  logic       enabled_r;
  logic [6:0] volume_r;
  logic [7:0] page_r, addr_r, wdata_r;
  logic       mapped;
  logic [7:0] rd_data;
  logic signed [15:0] left, right;
  wts_pkg::dp_cmd_t cmd;
  wts_pkg::dp_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      volume_r <= 7'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wts_pkg::CFG_ENABLED: enabled_r <= cfg_data[0];
        wts_pkg::CFG_VOLUME: volume_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // bus request capture
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      page_r <= in_ch.page;
      addr_r <= in_ch.address;
      wdata_r <= in_ch.write_data;
    end
  end

  assign mapped = enabled_r && (page_r[7:4] == 4'h3);

  wts_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_op(in_ch.op),
    .in_cycles(in_ch.cycles),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_kind(out_ch.kind), .out_last(out_ch.last),
    .cmd(cmd), .sts(sts)
  );

  wts_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .bus_page(page_r), .bus_addr(addr_r), .bus_wdata(wdata_r), .bus_mapped(mapped),
    .volume(volume_r), .rd_data(rd_data), .left(left), .right(right)
  );

  assign out_ch.read_data = (out_ch.kind == wts_pkg::KIND_READ) ? rd_data : 8'd0;
  assign out_ch.left = (out_ch.kind == wts_pkg::KIND_FRAME) ? left : 16'sd0;
  assign out_ch.right = (out_ch.kind == wts_pkg::KIND_FRAME) ? right : 16'sd0;

  a_no_accept_while_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input taken with result pending");
  a_read_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.kind == wts_pkg::KIND_READ) |-> out_ch.last)
    else $error("read result without last");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid) else $error("result dropped");
endmodule
